[hw/rtl/i2cm_pkg.sv]
package i2cm_pkg;

	// Input beat: a line sample plus an optional command
	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  op;
		logic [6:0]  dev_addr;
		logic [15:0] write_count;
		logic [15:0] read_count;
		logic [7:0]  tx_byte;
		logic        sda_in;
		logic        scl_in;
	} in_item_t;

	// Output beat: line drive and status for one clock of the bus
	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
		logic       tx_request;
		logic       done_res;
		logic [2:0] status;
		logic       active;
	} out_item_t;

	// Configuration register set
	typedef struct packed {
		logic        enable;
		logic [7:0]  scl_high_count;
		logic [7:0]  scl_low_count;
		logic [2:0]  clock_shift;
		logic [23:0] timeout_ticks;
		logic [4:0]  recovery_pulses;
	} cfg_t;

	typedef enum logic [3:0] {
		P_IDLE, P_START, P_A_LOW, P_A_HIGH, P_T_LOW, P_T_HIGH, P_R_LOW, P_R_HIGH,
		P_TXW, P_RS_LOW, P_RS_HIGH, P_STOP_LOW, P_STOP_HIGH, P_STOP_DONE,
		P_REC_HIGH, P_REC_LOW
	} phase_t;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_START   = 2'd1;
	localparam logic [1:0] FUNC_TX      = 2'd2;
	localparam logic [1:0] FUNC_RECOVER = 2'd3;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WR_RD = 2'd2;
	localparam logic [1:0] OP_PROBE = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NACK    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_BUSY    = 3'd3;
	localparam logic [2:0] ST_PARAM   = 3'd4;

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_SCL_HIGH = 3'd1;
	localparam logic [2:0] REG_SCL_LOW  = 3'd2;
	localparam logic [2:0] REG_SHIFT    = 3'd3;
	localparam logic [2:0] REG_TIMEOUT  = 3'd4;
	localparam logic [2:0] REG_RECOVERY = 3'd5;

endpackage

[hw/rtl/i2cm_fifo.sv]
module i2cm_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_stall  = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

[hw/rtl/i2cm_core.sv]
module i2cm_core #(
	parameter int COUNT_BITS   = 16,
	parameter int TIMEOUT_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cm_pkg::cfg_t       cfg,
	input  logic                 fire,
	input  i2cm_pkg::in_item_t   item,
	output i2cm_pkg::out_item_t  res
);
	import i2cm_pkg::*;

	localparam logic [15:0] CNT_MAX = 16'((17'd1 << COUNT_BITS) - 17'd1);
	localparam logic [TIMEOUT_BITS-1:0] TMO_MAX = '1;

	phase_t                  phase_q, n_phase;
	logic [3:0]              bit_q, n_bit;
	logic [7:0]              shift_q, n_shift;
	logic [COUNT_BITS-1:0]   writes_q, n_writes;
	logic [COUNT_BITS-1:0]   reads_q, n_reads;
	logic [15:0]             pc_q, n_pc;
	logic [TIMEOUT_BITS-1:0] wait_q, n_wait;
	logic                    busy_q, n_busy;
	logic [6:0]              target_q, n_target;
	logic [1:0]              kind_q, n_kind;
	logic [7:0]              pend_q, n_pend;
	logic                    pend_full_q, n_pend_full;
	logic [4:0]              pulses_q, n_pulses;
	logic [1:0]              lines_q, n_lines;
	logic [2:0]              fs_q, n_fs;
	logic                    inrec_q, n_inrec;
	logic                    sda_prev_q, n_sda_prev;

	logic [7:0]  hcnt, lcnt;
	logic [15:0] half_hi, half_lo;

	// half period lengths in clocks
	always_comb begin
		hcnt    = (cfg.scl_high_count == 8'd0) ? 8'd1 : cfg.scl_high_count;
		lcnt    = (cfg.scl_low_count == 8'd0) ? 8'd1 : cfg.scl_low_count;
		half_hi = 16'({8'd0, hcnt} << cfg.clock_shift);
		half_lo = 16'({8'd0, lcnt} << cfg.clock_shift);
	end

	// one bus clock step
	always_comb begin
		logic was_active, sda, scl, hi_end, hi_to, stop_req, fin, b, sl, dl;
		logic [2:0] stop_st;
		logic [15:0] wc, rc;

		sda = item.sda_in;
		scl = item.scl_in;
		n_phase = phase_q; n_bit = bit_q; n_shift = shift_q; n_writes = writes_q;
		n_reads = reads_q; n_pc = pc_q; n_wait = wait_q; n_busy = busy_q;
		n_target = target_q; n_kind = kind_q; n_pend = pend_q;
		n_pend_full = pend_full_q; n_pulses = pulses_q; n_fs = fs_q;
		n_inrec = inrec_q;
		res = '0;
		hi_end = 1'b0; hi_to = 1'b0; stop_req = 1'b0; fin = 1'b0; stop_st = ST_OK;
		wc = item.write_count; rc = item.read_count;

		// start / stop seen on the lines
		if (lines_q[1] && scl) begin
			if (lines_q[0] && !sda) n_busy = 1'b1;
			if (!lines_q[0] && sda) n_busy = 1'b0;
		end
		n_lines = {scl, sda};
		was_active = (phase_q != P_IDLE);

		if (was_active) begin
			case (phase_q)
				P_START, P_RS_HIGH, P_A_HIGH, P_T_HIGH, P_R_HIGH, P_STOP_HIGH,
				P_STOP_DONE, P_REC_HIGH: begin
					if (!scl) begin
						if (wait_q != TMO_MAX) n_wait = TIMEOUT_BITS'(wait_q + 1'b1);
						if (32'(n_wait) >= 32'(cfg.timeout_ticks) || n_wait == TMO_MAX)
							hi_to = 1'b1;
					end else begin
						n_pc = 16'(pc_q + 16'd1);
						if (n_pc >= half_hi) hi_end = 1'b1;
					end
				end
				P_A_LOW, P_T_LOW, P_R_LOW, P_RS_LOW, P_STOP_LOW, P_REC_LOW: begin
					n_pc = 16'(pc_q + 16'd1);
					if (n_pc > half_lo) begin
						n_pc = '0;
						n_wait = '0;
						case (phase_q)
							P_A_LOW:    n_phase = P_A_HIGH;
							P_T_LOW:    n_phase = P_T_HIGH;
							P_R_LOW:    n_phase = P_R_HIGH;
							P_RS_LOW:   n_phase = P_RS_HIGH;
							P_STOP_LOW: n_phase = P_STOP_HIGH;
							default: begin
								if (pulses_q != 5'd31) n_pulses = 5'(pulses_q + 5'd1);
								n_phase = P_REC_HIGH;
							end
						endcase
					end
				end
				P_TXW: begin
					if (pend_full_q) begin
						n_shift = pend_q;
						n_pend_full = 1'b0;
						if (writes_q != '0) n_writes = COUNT_BITS'(writes_q - 1'b1);
						n_bit = '0;
						n_phase = P_T_LOW; n_pc = '0; n_wait = '0;
					end else begin
						if (wait_q != TMO_MAX) n_wait = TIMEOUT_BITS'(wait_q + 1'b1);
						if (32'(n_wait) >= 32'(cfg.timeout_ticks) || n_wait == TMO_MAX) begin
							stop_req = 1'b1; stop_st = ST_TIMEOUT;
						end
					end
				end
				default: begin
					n_phase = P_IDLE; n_pc = '0; n_wait = '0;
				end
			endcase
		end

		// timeout in a high half
		if (hi_to) begin
			if (phase_q inside {P_STOP_HIGH, P_STOP_DONE}) begin
				if (n_fs == ST_OK) n_fs = ST_TIMEOUT;
				fin = 1'b1;
			end else begin
				stop_req = 1'b1; stop_st = ST_TIMEOUT;
			end
		end

		// end of a high half, SDA sampled here
		if (hi_end) begin
			n_pc = '0; n_wait = '0;
			case (phase_q)
				P_START: begin
					n_bit = '0; n_phase = P_A_LOW;
				end
				P_RS_HIGH: begin
					n_shift = {target_q, 1'b1}; n_phase = P_START;
				end
				P_A_HIGH, P_T_HIGH: begin
					if (bit_q < 4'd8) begin
						n_bit = 4'(bit_q + 4'd1);
						n_phase = (phase_q == P_A_HIGH) ? P_A_LOW : P_T_LOW;
					end else if (sda) begin
						stop_req = 1'b1; stop_st = ST_NACK;
					end else if (phase_q == P_A_HIGH && shift_q[0]) begin
						n_bit = '0; n_shift = '0; n_phase = P_R_LOW;
					end else if (kind_q == OP_PROBE) begin
						stop_req = 1'b1;
					end else if (writes_q != '0) begin
						n_phase = P_TXW;
					end else if (kind_q == OP_WR_RD) begin
						n_phase = P_RS_LOW;
					end else begin
						stop_req = 1'b1;
					end
				end
				P_R_HIGH: begin
					if (bit_q < 4'd8) begin
						n_shift = {shift_q[6:0], sda};
						if (bit_q == 4'd7) begin
							res.rx_valid = 1'b1;
							res.rx_byte  = n_shift;
							res.rx_last  = (reads_q <= COUNT_BITS'(1));
						end
						n_bit = 4'(bit_q + 4'd1);
						n_phase = P_R_LOW;
					end else if (reads_q <= COUNT_BITS'(1)) begin
						n_reads = '0; stop_req = 1'b1;
					end else begin
						n_reads = COUNT_BITS'(reads_q - 1'b1);
						n_bit = '0; n_shift = '0; n_phase = P_R_LOW;
					end
				end
				P_STOP_HIGH: n_phase = P_STOP_DONE;
				P_STOP_DONE: begin
					if (!inrec_q && fs_q == ST_OK && (kind_q inside {OP_READ, OP_WR_RD}) && !sda)
					begin
						n_inrec = 1'b1; n_pulses = '0; n_phase = P_REC_HIGH;
					end else begin
						fin = 1'b1;
					end
				end
				default: begin
					if (sda || pulses_q >= cfg.recovery_pulses) stop_req = 1'b1;
					else n_phase = P_REC_LOW;
				end
			endcase
		end

		if (stop_req) begin
			if (n_fs == ST_OK) n_fs = stop_st;
			n_phase = P_STOP_LOW; n_pc = '0; n_wait = '0;
		end
		if (fin) begin
			res.done_res = 1'b1;
			res.status = n_fs;
			n_phase = P_IDLE; n_pc = '0; n_wait = '0;
			n_pend_full = 1'b0; n_busy = 1'b0; n_inrec = 1'b0;
		end

		// commands
		if (item.func == FUNC_TX) begin
			n_pend = item.tx_byte;
			n_pend_full = 1'b1;
		end else if (item.func == FUNC_START && !was_active) begin
			if (!cfg.enable || ((item.op inside {OP_READ, OP_WR_RD}) && rc == 16'd0)) begin
				res.done_res = 1'b1; res.status = ST_PARAM;
			end else if (n_busy) begin
				res.done_res = 1'b1; res.status = ST_BUSY;
			end else begin
				n_target = item.dev_addr;
				n_kind   = item.op;
				n_writes = COUNT_BITS'((wc > CNT_MAX) ? CNT_MAX : wc);
				n_reads  = COUNT_BITS'((rc > CNT_MAX) ? CNT_MAX : rc);
				n_fs     = ST_OK;
				n_inrec  = 1'b0;
				n_shift  = {item.dev_addr, item.op == OP_READ};
				n_phase = P_START; n_pc = '0; n_wait = '0;
			end
		end else if (item.func == FUNC_RECOVER && !was_active) begin
			if (!cfg.enable) begin
				res.done_res = 1'b1; res.status = ST_PARAM;
			end else begin
				n_fs = ST_OK; n_inrec = 1'b1; n_pulses = '0;
				n_phase = P_REC_HIGH; n_pc = '0; n_wait = '0;
			end
		end

		// line drive
		sl = (n_phase inside {P_A_LOW, P_T_LOW, P_R_LOW, P_TXW, P_RS_LOW, P_STOP_LOW,
			P_REC_LOW});
		b = 1'b1;
		case (n_phase)
			P_A_LOW, P_A_HIGH, P_T_LOW, P_T_HIGH: begin
				if (n_bit < 4'd8) b = n_shift[3'(4'd7 - n_bit)];
				dl = !b;
			end
			P_R_LOW, P_R_HIGH: dl = (n_bit == 4'd8 && n_reads > COUNT_BITS'(1));
			P_START, P_STOP_LOW, P_STOP_HIGH: dl = 1'b1;
			default: dl = 1'b0;
		endcase
		// hold SDA on the first clock after SCL falls
		if (sl && n_phase != P_TXW && n_pc == 16'd0) dl = sda_prev_q;
		n_sda_prev = dl;

		res.scl_low    = sl;
		res.sda_low    = dl;
		res.tx_request = (n_phase == P_TXW) && !n_pend_full;
		res.active     = (n_phase != P_IDLE);
	end

	// transmit holding byte
	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q <= n_pend;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; bit_q <= '0; shift_q <= '0; writes_q <= '0;
			reads_q <= '0; pc_q <= '0; wait_q <= '0; busy_q <= 1'b0;
			target_q <= '0; kind_q <= '0; pend_full_q <= 1'b0; pulses_q <= '0;
			lines_q <= 2'b11; fs_q <= ST_OK; inrec_q <= 1'b0; sda_prev_q <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase; bit_q <= n_bit; shift_q <= n_shift;
			writes_q <= n_writes; reads_q <= n_reads; pc_q <= n_pc;
			wait_q <= n_wait; busy_q <= n_busy; target_q <= n_target;
			kind_q <= n_kind; pend_full_q <= n_pend_full; pulses_q <= n_pulses;
			lines_q <= n_lines; fs_q <= n_fs; inrec_q <= n_inrec;
			sda_prev_q <= n_sda_prev;
		end
	end

endmodule

[hw/rtl/i2c_master_transaction_engine.sv]
// Polled seven-bit I2C master, one bus clock per beat.
// Input channel (in_valid/in_stall/in_data): each beat carries the sampled
// SDA and SCL levels and optionally a command (start, transmit byte, recovery).
// Output channel (out_valid/out_stall/out_data): exactly one beat per input
// beat, carrying the open-drain drive for SCL and SDA, received bytes, the
// transmit request, completion status and the active flag.
// Configuration sits on an APB port, registers at byte offsets 4*i; write
// only while the engine is idle. pready is tied high.
// An accepted beat's result is registered in the input queue and then in the
// output queue. Throughput: one beat per cycle while the output is not
// stalled, set by the combinational sequencer step between the input and output queues.
// A stall on the output fills the two-entry output queue, then stops the
// sequencer, then fills the two-entry input queue and raises in_stall.
// Reset clears the queues and the sequencer: idle, bus free, lines seen high,
// and restores the register defaults (master disabled).
module i2c_master_transaction_engine #(
	parameter int COUNT_BITS   = 16,
	parameter int TIMEOUT_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  i2cm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output i2cm_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import i2cm_pkg::*;

	cfg_t      cfg_q;
	logic      q_valid, q_stall, fire;
	logic [$bits(in_item_t)-1:0]  q_data;
	in_item_t  item;
	out_item_t res;
	logic [$bits(out_item_t)-1:0] out_raw;
	logic      wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.scl_high_count  <= 8'd13;
			cfg_q.scl_low_count   <= 8'd20;
			cfg_q.clock_shift     <= 3'd2;
			cfg_q.timeout_ticks   <= 24'd200000;
			cfg_q.recovery_pulses <= 5'd16;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLE:   cfg_q.enable          <= pwdata[0];
				REG_SCL_HIGH: cfg_q.scl_high_count  <= pwdata[7:0];
				REG_SCL_LOW:  cfg_q.scl_low_count   <= pwdata[7:0];
				REG_SHIFT:    cfg_q.clock_shift     <= pwdata[2:0];
				REG_TIMEOUT:  cfg_q.timeout_ticks   <= pwdata[23:0];
				REG_RECOVERY: cfg_q.recovery_pulses <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_ENABLE:   prdata = {31'd0, cfg_q.enable};
			REG_SCL_HIGH: prdata = {24'd0, cfg_q.scl_high_count};
			REG_SCL_LOW:  prdata = {24'd0, cfg_q.scl_low_count};
			REG_SHIFT:    prdata = {29'd0, cfg_q.clock_shift};
			REG_TIMEOUT:  prdata = {8'd0, cfg_q.timeout_ticks};
			REG_RECOVERY: prdata = {27'd0, cfg_q.recovery_pulses};
			default:      prdata = 32'd0;
		endcase
	end

	// front: input queue
	i2cm_fifo #(.WIDTH($bits(in_item_t))) u_in_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (q_valid),
		.out_stall (q_stall),
		.out_data  (q_data)
	);

	assign item = in_item_t'(q_data);
	assign fire = q_valid && !q_stall;

	// back: bus sequencer
	i2cm_core #(.COUNT_BITS(COUNT_BITS), .TIMEOUT_BITS(TIMEOUT_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fire   (fire),
		.item   (item),
		.res    (res)
	);

	// result queue
	i2cm_fifo #(.WIDTH($bits(out_item_t))) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_stall  (q_stall),
		.in_data   (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_raw)
	);

	assign out_data = out_item_t'(out_raw);

endmodule

[tb/i2cm_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every output beat
// from the accepted input beats and compares them in order.
module i2cm_checker
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	input  logic      pready,
	output int        fails,
	output int        pending,
	output logic      engine_busy,
	output int        done_seen
);

	localparam int unsigned WAIT_MAX = 24'hFFFFFF;
	localparam int unsigned LEN_MAX  = 16'hFFFF;

	// register copy
	logic        en;
	logic [7:0]  hi_cnt, lo_cnt;
	logic [2:0]  shift;
	logic [23:0] tmo;
	logic [4:0]  rec_max;

	// sequencer copy
	phase_t      ph;
	int unsigned bitn, wr_left, rd_left, per_cnt, wait_cnt, pulses;
	logic [7:0]  shreg, pend_byte;
	logic [6:0]  tgt;
	logic [1:0]  kind, last_lines;
	logic [2:0]  fin_status;
	logic        bus_taken, pend_full, recovering, sda_drv_prev;

	// per-beat outputs
	logic [7:0]  rx_b;
	logic        rx_v, rx_l, done_f;
	logic [2:0]  st_f;

	out_item_t   bus_beats_q[$];

	function automatic int unsigned half_len(logic [7:0] c);
		return ((c == 0) ? 32'd1 : 32'(c)) << shift;
	endfunction

	function automatic void enter(phase_t p);
		ph = p;
		per_cnt = 0;
		wait_cnt = 0;
	endfunction

	function automatic bit waited();
		if (wait_cnt < WAIT_MAX) wait_cnt++;
		return wait_cnt >= tmo || wait_cnt == WAIT_MAX;
	endfunction

	function automatic bit low_done();
		per_cnt++;
		return per_cnt > half_len(lo_cnt);
	endfunction

	// 0 keep going, 1 end of high half, 2 timed out
	function automatic int high_step(logic scl);
		if (!scl) return waited() ? 2 : 0;
		per_cnt++;
		return (per_cnt >= half_len(hi_cnt)) ? 1 : 0;
	endfunction

	function automatic void begin_stop(logic [2:0] st);
		if (fin_status == ST_OK) fin_status = st;
		enter(P_STOP_LOW);
	endfunction

	function automatic void finish();
		done_f = 1'b1;
		st_f = fin_status;
		enter(P_IDLE);
		pend_full = 1'b0;
		bus_taken = 1'b0;
		recovering = 1'b0;
	endfunction

	function automatic void after_ack();
		if (kind == OP_PROBE) begin_stop(ST_OK);
		else if (wr_left != 0) enter(P_TXW);
		else if (kind == OP_WR_RD) enter(P_RS_LOW);
		else begin_stop(ST_OK);
	endfunction

	// SDA is sampled on the last clock of a high half
	function automatic void end_of_high(logic sda);
		case (ph)
			P_START: begin
				bitn = 0;
				enter(P_A_LOW);
			end
			P_RS_HIGH: begin
				shreg = {tgt, 1'b1};
				enter(P_START);
			end
			P_A_HIGH, P_T_HIGH: begin
				if (bitn < 8) begin
					bitn++;
					enter(ph == P_A_HIGH ? P_A_LOW : P_T_LOW);
				end else if (sda) begin
					begin_stop(ST_NACK);
				end else if (ph == P_A_HIGH && shreg[0]) begin
					bitn = 0;
					shreg = '0;
					enter(P_R_LOW);
				end else begin
					after_ack();
				end
			end
			P_R_HIGH: begin
				if (bitn < 8) begin
					shreg = {shreg[6:0], sda};
					if (bitn == 7) begin
						rx_v = 1'b1;
						rx_b = shreg;
						rx_l = rd_left <= 1;
					end
					bitn++;
					enter(P_R_LOW);
				end else if (rd_left <= 1) begin
					rd_left = 0;
					begin_stop(ST_OK);
				end else begin
					rd_left--;
					bitn = 0;
					shreg = '0;
					enter(P_R_LOW);
				end
			end
			P_STOP_HIGH: enter(P_STOP_DONE);
			P_STOP_DONE: begin
				// slave still holding SDA after a good read: clock it free
				if (!recovering && fin_status == ST_OK &&
				    (kind == OP_READ || kind == OP_WR_RD) && !sda) begin
					recovering = 1'b1;
					pulses = 0;
					enter(P_REC_HIGH);
				end else begin
					finish();
				end
			end
			default: begin
				if (sda || pulses >= rec_max) begin_stop(ST_OK);
				else enter(P_REC_LOW);
			end
		endcase
	endfunction

	function automatic void advance(logic sda, logic scl);
		int r;
		case (ph)
			P_START, P_RS_HIGH, P_A_HIGH, P_T_HIGH, P_R_HIGH, P_STOP_HIGH,
			P_STOP_DONE, P_REC_HIGH: begin
				r = high_step(scl);
				if (r == 2) begin
					// a timeout inside the stop ends at once
					if (ph == P_STOP_HIGH || ph == P_STOP_DONE) begin
						if (fin_status == ST_OK) fin_status = ST_TIMEOUT;
						finish();
					end else begin
						begin_stop(ST_TIMEOUT);
					end
				end else if (r == 1) begin
					end_of_high(sda);
				end
			end
			P_A_LOW:    if (low_done()) enter(P_A_HIGH);
			P_T_LOW:    if (low_done()) enter(P_T_HIGH);
			P_R_LOW:    if (low_done()) enter(P_R_HIGH);
			P_RS_LOW:   if (low_done()) enter(P_RS_HIGH);
			P_STOP_LOW: if (low_done()) enter(P_STOP_HIGH);
			P_REC_LOW: begin
				if (low_done()) begin
					if (pulses < 31) pulses++;
					enter(P_REC_HIGH);
				end
			end
			P_TXW: begin
				if (pend_full) begin
					shreg = pend_byte;
					pend_full = 1'b0;
					if (wr_left != 0) wr_left--;
					bitn = 0;
					enter(P_T_LOW);
				end else if (waited()) begin
					begin_stop(ST_TIMEOUT);
				end
			end
			default: enter(P_IDLE);
		endcase
	endfunction

	function automatic out_item_t bus_step(in_item_t it);
		out_item_t o;
		logic was_act, sl, dl;
		was_act = ph != P_IDLE;
		// start and stop conditions seen on the lines
		if (last_lines[1] && it.scl_in) begin
			if (last_lines[0] && !it.sda_in) bus_taken = 1'b1;
			if (!last_lines[0] && it.sda_in) bus_taken = 1'b0;
		end
		last_lines = {it.scl_in, it.sda_in};
		rx_b = '0; rx_v = 1'b0; rx_l = 1'b0; done_f = 1'b0; st_f = ST_OK;

		if (was_act) advance(it.sda_in, it.scl_in);

		if (it.func == FUNC_TX) begin
			pend_byte = it.tx_byte;
			pend_full = 1'b1;
		end else if (it.func == FUNC_START && !was_act) begin
			if (!en || ((it.op == OP_READ || it.op == OP_WR_RD) && it.read_count == 0)) begin
				done_f = 1'b1; st_f = ST_PARAM;
			end else if (bus_taken) begin
				done_f = 1'b1; st_f = ST_BUSY;
			end else begin
				tgt = it.dev_addr;
				kind = it.op;
				wr_left = (it.write_count > LEN_MAX) ? LEN_MAX : it.write_count;
				rd_left = (it.read_count > LEN_MAX) ? LEN_MAX : it.read_count;
				fin_status = ST_OK;
				recovering = 1'b0;
				shreg = {it.dev_addr, it.op == OP_READ};
				enter(P_START);
			end
		end else if (it.func == FUNC_RECOVER && !was_act) begin
			if (!en) begin
				done_f = 1'b1; st_f = ST_PARAM;
			end else begin
				fin_status = ST_OK;
				recovering = 1'b1;
				pulses = 0;
				enter(P_REC_HIGH);
			end
		end

		sl = ph inside {P_A_LOW, P_T_LOW, P_R_LOW, P_TXW, P_RS_LOW, P_STOP_LOW, P_REC_LOW};
		case (ph)
			P_A_LOW, P_A_HIGH, P_T_LOW, P_T_HIGH: dl = (bitn < 8) ? ~shreg[7 - bitn] : 1'b0;
			P_R_LOW, P_R_HIGH: dl = bitn == 8 && rd_left > 1;
			P_START, P_STOP_LOW, P_STOP_HIGH: dl = 1'b1;
			default: dl = 1'b0;
		endcase
		// SDA holds on the first clock of a low half
		if (sl && ph != P_TXW && per_cnt == 0) dl = sda_drv_prev;
		sda_drv_prev = dl;

		o.scl_low = sl;
		o.sda_low = dl;
		o.rx_byte = rx_b;
		o.rx_valid = rx_v;
		o.rx_last = rx_l;
		o.tx_request = ph == P_TXW && !pend_full;
		o.done_res = done_f;
		o.status = st_f;
		o.active = ph != P_IDLE;
		return o;
	endfunction

	function automatic void cmp(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			en = 1'b0; hi_cnt = 8'd13; lo_cnt = 8'd20; shift = 3'd2;
			tmo = 24'd200000; rec_max = 5'd16;
			ph = P_IDLE; bitn = 0; shreg = '0; wr_left = 0; rd_left = 0;
			per_cnt = 0; wait_cnt = 0; bus_taken = 1'b0; tgt = '0; kind = '0;
			pend_byte = '0; pend_full = 1'b0; pulses = 0; last_lines = 2'b11;
			fin_status = ST_OK; recovering = 1'b0; sda_drv_prev = 1'b0;
			bus_beats_q.delete();
			fails = 0;
			pending <= 0;
			engine_busy <= 1'b0;
			done_seen <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ENABLE:   en = pwdata[0];
					REG_SCL_HIGH: hi_cnt = pwdata[7:0];
					REG_SCL_LOW:  lo_cnt = pwdata[7:0];
					REG_SHIFT:    shift = pwdata[2:0];
					REG_TIMEOUT:  tmo = pwdata[23:0];
					REG_RECOVERY: rec_max = pwdata[4:0];
					default: ;
				endcase
			end
			// result beats
			if (out_valid && !out_stall) begin
				if (bus_beats_q.size() == 0) begin
					$error("output beat with no expectation waiting");
					fails++;
				end else begin
					e = bus_beats_q.pop_front();
					cmp("scl_low", e.scl_low, out_data.scl_low);
					cmp("sda_low", e.sda_low, out_data.sda_low);
					cmp("rx_byte", e.rx_byte, out_data.rx_byte);
					cmp("rx_valid", e.rx_valid, out_data.rx_valid);
					cmp("rx_last", e.rx_last, out_data.rx_last);
					cmp("tx_request", e.tx_request, out_data.tx_request);
					cmp("done_res", e.done_res, out_data.done_res);
					cmp("status", e.status, out_data.status);
					cmp("active", e.active, out_data.active);
					if (e.done_res) done_seen <= done_seen + 1;
				end
			end
			// input beats
			if (in_valid && !in_stall) bus_beats_q.push_back(bus_step(in_data));
			pending <= bus_beats_q.size();
			engine_busy <= ph != P_IDLE;
		end
	end

endmodule

[tb/tb_i2c_master_transaction_engine.sv]
`timescale 1ns / 1ps

module tb_i2c_master_transaction_engine;
	import i2cm_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int N_SETTINGS = 6;
	localparam int BEATS_PER_SETTING = 195;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	in_item_t    in_data;
	out_item_t   out_data;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	int   fails, pending, done_seen;
	logic engine_busy;

	int   n_beats;
	int   quiet;
	int   hold_reqs, hold_seen;
	int   rx_stall_left, hold_left;
	int   idle_cycles;

	i2c_master_transaction_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	i2cm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fails(fails), .pending(pending), .engine_busy(engine_busy),
		.done_seen(done_seen)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// receiver: random stall per beat, plus long holds on request
	always @(posedge clk) begin
		int w;
		int nxt_stall, nxt_hold;
		logic stall_v;
		nxt_stall = rx_stall_left;
		nxt_hold = hold_left;
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			nxt_hold = 400;
		end
		if (nxt_hold > 0) begin
			nxt_hold--;
			stall_v = 1'b1;
		end else if (nxt_stall > 0) begin
			nxt_stall--;
			stall_v = 1'b1;
		end else if (out_valid && !out_stall) begin
			w = quiet ? 0 : $urandom_range(0, 18);
			stall_v = w != 0;
			nxt_stall = (w != 0) ? w - 1 : 0;
		end else begin
			stall_v = 1'b0;
		end
		out_stall <= stall_v;
		rx_stall_left <= nxt_stall;
		hold_left <= nxt_hold;
	end

	// watchdog on cycles with no beat accepted on either side and no register access
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("** i2c_master_transaction_engine: FAILED **");
			$finish;
		end
	end

	task automatic send_beat(in_item_t b);
		int g;
		g = quiet ? 0 : $urandom_range(0, 18);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_data <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_beats++;
	endtask

	task automatic beat(logic [1:0] f, logic [1:0] o, logic [6:0] a, logic [15:0] wc,
	                    logic [15:0] rc, logic [7:0] tx, logic sda, logic scl);
		in_item_t b;
		b = '{func: f, op: o, dev_addr: a, write_count: wc, read_count: rc,
		      tx_byte: tx, sda_in: sda, scl_in: scl};
		send_beat(b);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// bring the engine to idle and wait out every expected beat
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (engine_busy) begin
			// released lines NACK anything still running
			beat(FUNC_TX, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'($urandom), 1'b1, 1'b1);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic in_item_t rand_beat();
		in_item_t b;
		int r;
		b.dev_addr = 7'($urandom);
		b.tx_byte = 8'($urandom);
		b.op = 2'($urandom);
		r = $urandom_range(0, 99);
		if (!engine_busy)
			b.func = (r < 35) ? FUNC_START : (r < 50) ? FUNC_TX :
			         (r < 54) ? FUNC_RECOVER : FUNC_TICK;
		else
			b.func = (r < 15) ? FUNC_TX : (r < 17) ? FUNC_START :
			         (r < 18) ? FUNC_RECOVER : FUNC_TICK;
		b.write_count = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		if (b.op == OP_READ || b.op == OP_WR_RD)
			b.read_count = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 3));
		else
			b.read_count = 16'($urandom);
		b.scl_in = $urandom_range(0, 9) != 0;
		b.sda_in = engine_busy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0);
		return b;
	endfunction

	initial begin
		logic [31:0] cfg_set[N_SETTINGS][6];
		cfg_set = '{
			'{1, 1, 1, 0, 30, 31},
			'{1, 255, 255, 0, 24'hFFFFFF, 0},
			'{1, 1, 2, 7, 1, 5},
			'{0, 3, 3, 0, 20, 2},
			'{1, 2, 1, 1, 50, 16},
			'{1, 1, 1, 0, 8, 3}
		};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		in_data.sda_in = 1'b1;
		in_data.scl_in = 1'b1;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		out_stall = 1'b0;
		n_beats = 0; quiet = 1; hold_reqs = 0; hold_seen = 0;
		rx_stall_left = 0; hold_left = 0; idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: commands are refused
		beat(FUNC_START, OP_WRITE, 7'h7F, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		beat(FUNC_RECOVER, OP_READ, 7'h00, 16'h0, 16'h0, 8'h00, 1'b1, 1'b1);
		settle();
		reg_write(REG_ENABLE, 1);
		reg_write(REG_SCL_HIGH, 1);
		reg_write(REG_SCL_LOW, 1);
		reg_write(REG_SHIFT, 0);
		reg_write(REG_TIMEOUT, 12);
		reg_write(REG_RECOVERY, 2);
		// read with zero count, then a bus taken by another master
		beat(FUNC_START, OP_READ, 7'h2A, 16'h0, 16'h0, 8'h00, 1'b1, 1'b1);
		beat(FUNC_TICK, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b0, 1'b1);
		beat(FUNC_START, OP_WRITE, 7'h55, 16'h1, 16'h0, 8'h00, 1'b0, 1'b1);
		beat(FUNC_TICK, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b1, 1'b1);
		// probe, one-byte write and read with SDA held low afterwards
		beat(FUNC_START, OP_PROBE, 7'h7F, 16'h0, 16'h0, 8'h00, 1'b1, 1'b1);
		repeat (40) beat(FUNC_TICK, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b0, 1'b1);
		settle();
		beat(FUNC_START, OP_WR_RD, 7'h00, 16'h1, 16'h1, 8'h00, 1'b1, 1'b1);
		beat(FUNC_TX, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'hA5, 1'b0, 1'b1);
		repeat (120) beat(FUNC_TICK, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b0, 1'b1);
		settle();
		beat(FUNC_RECOVER, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b0, 1'b1);
		repeat (8) beat(FUNC_TICK, OP_WRITE, 7'h0, 16'h0, 16'h0, 8'h00, 1'b0, 1'b0);
		settle();

		// random part, one register setting at a time
		for (int s = 0; s < N_SETTINGS; s++) begin
			for (int i = 0; i < 6; i++) reg_write(3'(i), cfg_set[s][i]);
			for (int n = 0; n < BEATS_PER_SETTING; n++) begin
				if (n % 40 == 0) quiet = $urandom_range(0, 2) == 0;
				if (n == 60 && s == N_SETTINGS - 1) hold_reqs++;
				if (n == 150 && s == 0) begin
					// let every expected beat drain before going on
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_beat(rand_beat());
			end
			settle();
		end

		repeat (10) @(posedge clk);
		$display("drove %0d input beats across %0d register settings,", n_beats, N_SETTINGS);
		$display("%0d transfers or refusals completed", done_seen);
		if (fails == 0 && pending == 0)
			$display("** i2c_master_transaction_engine: PASSED **");
		else
			$display("** i2c_master_transaction_engine: FAILED **");
		$finish;
	end

endmodule
